// File: rtl/tlptm_pkg.sv
`default_nettype none

package tlptm_pkg;

	// Fixed geometry of the two-level walk.
	localparam int DIR_ENTRIES       = 1024;
	localparam int ENTRIES_PER_TABLE = 1024;
	localparam int DIR_IDX_W         = 10;
	localparam int TBL_IDX_W         = 10;
	localparam int OFS_W             = 12;

	// Request codes.
	localparam logic [1:0] FN_MAP   = 2'd0;
	localparam logic [1:0] FN_UNMAP = 2'd1;
	localparam logic [1:0] FN_XLATE = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_ADDR   = 3'd1;
	localparam logic [2:0] ST_NO_SLOT    = 3'd2;
	localparam logic [2:0] ST_MAPPED     = 3'd3;
	localparam logic [2:0] ST_NOT_MAPPED = 3'd4;

	// Input word.
	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] vaddr;
		logic [31:0] paddr;
		logic [11:0] page_flags;
	} req_word_t;

	// Result word.
	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] phys_out;
	} rsp_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_req;
		logic       sweep_inc;
		logic       dir_init_wr;
		logic       pte_rd;
		logic       pte_clr_wr;
		logic       alloc_commit;
		logic       pte_wr_map;
		logic       pte_wr_zero;
		logic       res_valid;
		logic [2:0] res_status;
		logic       res_phys_en;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] func;
		logic       va_zero;
		logic       map_bad;
		logic       dir_present;
		logic       slot_full;
		logic       sweep_last;
		logic       pte_present;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/tlptm_dp.sv
`default_nettype none

module tlptm_dp import tlptm_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire req_word_t request,
	input  wire ctl_cmd_t  cmd,
	output dp_stat_t       stat,
	output rsp_word_t      result,
	output logic           done
);

	localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W    = $clog2(TABLE_SLOTS + 1);
	localparam int DIR_W    = SLOT_W + 1;
	localparam int PTE_DEP  = TABLE_SLOTS * ENTRIES_PER_TABLE;
	localparam int PTE_AW   = $clog2(PTE_DEP);

	// Memories: directory entries are {present, slot}, page entries are 32 bits.
	logic [DIR_W-1:0] dir_mem [DIR_ENTRIES];
	logic [31:0]      pte_mem [PTE_DEP];

	req_word_t              req_q;
	logic [DIR_W-1:0]       dir_rd_q;
	logic [31:0]            pte_rd_q;
	logic [CNT_W-1:0]       next_free_q;
	logic [TBL_IDX_W-1:0]   sweep_q;
	rsp_word_t              result_q;
	logic                   done_q;

	logic [DIR_IDX_W-1:0]   req_dir;
	logic [TBL_IDX_W-1:0]   req_tbl;
	logic [SLOT_W-1:0]      dir_slot;
	logic [SLOT_W-1:0]      free_slot;
	logic [31:0]            map_entry;
	logic                   dir_we;
	logic [DIR_IDX_W-1:0]   dir_wa;
	logic [DIR_W-1:0]       dir_wd;
	logic                   pte_we;
	logic [PTE_AW-1:0]      pte_wa;
	logic [31:0]            pte_wd;
	logic [PTE_AW-1:0]      pte_ra;

	assign req_dir   = req_q.vaddr[31:22];
	assign req_tbl   = req_q.vaddr[21:12];
	assign dir_slot  = dir_rd_q[SLOT_W-1:0];
	assign free_slot = SLOT_W'(next_free_q);
	assign map_entry = {req_q.paddr[31:OFS_W], req_q.page_flags | 12'h001};
	assign pte_ra    = PTE_AW'({dir_slot, req_tbl});

	// Status toward the controller.
	always_comb begin
		stat.func        = req_q.func;
		stat.va_zero     = (req_q.vaddr == 32'd0);
		stat.map_bad     = (req_q.vaddr == 32'd0) || (req_q.paddr == 32'd0) ||
		                   (req_q.vaddr[OFS_W-1:0] != '0) ||
		                   (req_q.paddr[OFS_W-1:0] != '0);
		stat.dir_present = dir_rd_q[DIR_W-1];
		stat.slot_full   = (next_free_q == CNT_W'(TABLE_SLOTS));
		stat.sweep_last  = (sweep_q == '1);
		stat.pte_present = pte_rd_q[0];
	end

	// Directory write port: init sweep or new table commit.
	always_comb begin
		dir_we = cmd.dir_init_wr || cmd.alloc_commit;
		dir_wa = cmd.dir_init_wr ? sweep_q : req_dir;
		dir_wd = cmd.dir_init_wr ? '0 : {1'b1, free_slot};
	end

	// Page entry write port: slot clear, new table entry, map or unmap.
	always_comb begin
		pte_we = 1'b1;
		pte_wa = PTE_AW'({dir_slot, req_tbl});
		pte_wd = 32'd0;
		priority if (cmd.pte_clr_wr) begin
			pte_wa = PTE_AW'({free_slot, sweep_q});
		end else if (cmd.alloc_commit) begin
			pte_wa = PTE_AW'({free_slot, req_tbl});
			pte_wd = map_entry;
		end else if (cmd.pte_wr_map) begin
			pte_wd = map_entry;
		end else if (cmd.pte_wr_zero) begin
			pte_wd = 32'd0;
		end else begin
			pte_we = 1'b0;
		end
	end

	// Directory memory with registered read at the incoming directory index.
	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_wa] <= dir_wd;
		end
		if (cmd.load_req) begin
			dir_rd_q <= dir_mem[request.vaddr[31:22]];
		end
	end

	// Page entry memory with registered read.
	always_ff @(posedge clk) begin
		if (pte_we) begin
			pte_mem[pte_wa] <= pte_wd;
		end
		if (cmd.pte_rd) begin
			pte_rd_q <= pte_mem[pte_ra];
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= request;
		end
		if (cmd.res_valid) begin
			result_q.status   <= cmd.res_status;
			result_q.phys_out <= cmd.res_phys_en ?
			                     {pte_rd_q[31:OFS_W], req_q.vaddr[OFS_W-1:0]} : 32'd0;
		end
	end

	// Control counters and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= '0;
			sweep_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.res_valid;
			if (cmd.sweep_inc) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.alloc_commit) begin
				next_free_q <= next_free_q + 1'b1;
			end
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

`default_nettype wire

// File: rtl/tlptm_ctrl.sv
`default_nettype none

module tlptm_ctrl import tlptm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      cmd,
	output logic          busy
);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DIR   = 3'd2;
	localparam logic [2:0] S_PTE   = 3'd3;
	localparam logic [2:0] S_CLEAR = 3'd4;
	localparam logic [2:0] S_NEW   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.dir_init_wr = 1'b1;
				cmd.sweep_inc   = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = S_DIR;
				end
			end
			S_DIR: begin
				state_d        = S_IDLE;
				cmd.res_valid  = 1'b1;
				cmd.res_status = ST_BAD_ADDR;
				unique case (stat.func)
					FN_MAP: begin
						priority if (stat.map_bad) begin
							cmd.res_status = ST_BAD_ADDR;
						end else if (stat.dir_present) begin
							cmd.res_valid = 1'b0;
							cmd.pte_rd    = 1'b1;
							state_d       = S_PTE;
						end else if (stat.slot_full) begin
							cmd.res_status = ST_NO_SLOT;
						end else begin
							cmd.res_valid = 1'b0;
							state_d       = S_CLEAR;
						end
					end
					FN_UNMAP, FN_XLATE: begin
						priority if (stat.va_zero) begin
							cmd.res_status = ST_BAD_ADDR;
						end else if (!stat.dir_present) begin
							cmd.res_status = ST_NOT_MAPPED;
						end else begin
							cmd.res_valid = 1'b0;
							cmd.pte_rd    = 1'b1;
							state_d       = S_PTE;
						end
					end
					default: begin
						cmd.res_status = ST_BAD_ADDR;
					end
				endcase
			end
			S_PTE: begin
				state_d       = S_IDLE;
				cmd.res_valid = 1'b1;
				unique case (stat.func)
					FN_MAP: begin
						if (stat.pte_present) begin
							cmd.res_status = ST_MAPPED;
						end else begin
							cmd.res_status = ST_OK;
							cmd.pte_wr_map = 1'b1;
						end
					end
					FN_UNMAP: begin
						if (stat.pte_present) begin
							cmd.res_status  = ST_OK;
							cmd.pte_wr_zero = 1'b1;
						end else begin
							cmd.res_status = ST_NOT_MAPPED;
						end
					end
					default: begin
						if (stat.pte_present) begin
							cmd.res_status  = ST_OK;
							cmd.res_phys_en = 1'b1;
						end else begin
							cmd.res_status = ST_NOT_MAPPED;
						end
					end
				endcase
			end
			S_CLEAR: begin
				cmd.pte_clr_wr = 1'b1;
				cmd.sweep_inc  = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_NEW;
				end
			end
			S_NEW: begin
				cmd.alloc_commit = 1'b1;
				cmd.res_valid    = 1'b1;
				cmd.res_status   = ST_OK;
				state_d          = S_IDLE;
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/two_level_page_table_manager_top.sv
`default_nettype none

// Two-level page table manager. A request word is taken at a rising edge with start high and
// busy low; its result word appears on result for exactly one cycle with done high and must
// be taken then, as the block cannot be stalled. After reset the block is busy while it
// sweeps the directory memory to not present. A request that hits an existing directory
// entry steps through a directory read, a page entry read, then update and result, as the
// two memory reads depend on each other; a request rejected at the directory level ends
// after the directory read. A map that allocates a new table first clears the new slot's
// 1024 page entries, one per cycle, and then writes the entry.
module two_level_page_table_manager_top import tlptm_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire req_word_t request,
	output logic           busy,
	output rsp_word_t      result,
	output logic           done
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	tlptm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	tlptm_dp #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result),
		.done    (done)
	);

endmodule

`default_nettype wire

// File: rtl/tlptm_checker.sv
`default_nettype none

module tlptm_checker import tlptm_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire rsp_word_t result,
	input wire logic      done
);

	// A result word is only shown once the request is finished.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	// An accepted word makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy after accept");

	// No result can come in the cycle right after an accept.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done) else $error("result too early");

	// Status stays within the defined codes.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status <= ST_NOT_MAPPED)) else $error("bad status code");

	// A failed request returns a zero address.
	a_phys_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_OK)) |-> (result.phys_out == 32'd0))
		else $error("address on failed request");

endmodule

bind two_level_page_table_manager_top tlptm_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.result (result),
	.done   (done)
);

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

module tb_top;
	import tlptm_pkg::*;

	localparam int TABLE_SLOTS = 16;
	localparam int RANDOM_WORDS = 1400;
	localparam int PAGE_POOL_MAX = 64;
	localparam int DIR_PICKS = 24;

	// Operation code that the block does not define; it must answer bad address.
	localparam logic [1:0] FN_NONE = 2'd3;

	// One row of the directed table.
	typedef struct {
		req_word_t req;
		bit        typed;
		rsp_word_t want;
	} plan_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	req_word_t request;
	logic      busy;
	rsp_word_t result;
	logic      done;

	// Shadow copy of the page tables.
	bit          dir_valid [DIR_ENTRIES];
	int          dir_slot_of [DIR_ENTRIES];
	logic [31:0] pte_mem [TABLE_SLOTS * ENTRIES_PER_TABLE];
	int          slots_used;

	rsp_word_t   pending_results [$];
	plan_row_t   plan [$];
	logic [31:0] mapped_pages [$];
	int          dir_pick [DIR_PICKS];
	int          mismatches;

	two_level_page_table_manager_top #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.result(result),
		.done(done)
	);

	always #4 clk = ~clk;

	// Runs one request word against the shadow tables and returns the answer it must give.
	function automatic rsp_word_t walk_and_update(req_word_t w);
		rsp_word_t   r;
		logic [9:0]  d;
		logic [9:0]  t;
		int          idx;
		bit          no_slot;
		r.status = ST_BAD_ADDR;
		r.phys_out = '0;
		d = w.vaddr[31:22];
		t = w.vaddr[21:12];
		no_slot = 1'b0;
		case (w.func)
			FN_MAP: begin
				if (w.vaddr != 0 && w.paddr != 0 && w.vaddr[11:0] == 0 &&
				    w.paddr[11:0] == 0) begin
					// A missing directory entry takes the next slot, cleared first.
					if (!dir_valid[d]) begin
						if (slots_used >= TABLE_SLOTS) begin
							no_slot = 1'b1;
							r.status = ST_NO_SLOT;
						end else begin
							for (int i = 0; i < ENTRIES_PER_TABLE; i++)
								pte_mem[slots_used * ENTRIES_PER_TABLE + i] = '0;
							dir_slot_of[d] = slots_used;
							dir_valid[d] = 1'b1;
							slots_used++;
						end
					end
					if (!no_slot) begin
						idx = dir_slot_of[d] * ENTRIES_PER_TABLE + int'(t);
						if (pte_mem[idx][0]) begin
							r.status = ST_MAPPED;
						end else begin
							pte_mem[idx] = {w.paddr[31:12], w.page_flags[11:1], 1'b1};
							r.status = ST_OK;
						end
					end
				end
			end
			FN_UNMAP, FN_XLATE: begin
				if (w.vaddr != 0) begin
					idx = dir_slot_of[d] * ENTRIES_PER_TABLE + int'(t);
					if (!dir_valid[d] || !pte_mem[idx][0]) begin
						r.status = ST_NOT_MAPPED;
					end else begin
						r.status = ST_OK;
						if (w.func == FN_UNMAP)
							pte_mem[idx] = '0;
						else
							r.phys_out = {pte_mem[idx][31:12], w.vaddr[11:0]};
					end
				end
			end
			default: begin
				r.status = ST_BAD_ADDR;
			end
		endcase
		return r;
	endfunction

	task automatic add_row(input logic [1:0] f, input logic [31:0] va, input logic [31:0] pa,
			input logic [11:0] fl, input bit typed, input logic [2:0] st);
		plan_row_t row;
		row.req.func = f;
		row.req.vaddr = va;
		row.req.paddr = pa;
		row.req.page_flags = fl;
		row.typed = typed;
		row.want.status = st;
		row.want.phys_out = '0;
		plan.push_back(row);
	endtask

	// Offers one word and holds it until the block takes it; the expectation is queued then.
	task automatic issue(input req_word_t w, input bit typed, input rsp_word_t want,
			output rsp_word_t predicted);
		start <= 1'b1;
		request <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = walk_and_update(w);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Holds the sender off until every queued result has come back.
	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Result checker: every done strobe must match the oldest expectation.
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result word: status %0d phys_out %h",
					result.status, result.phys_out);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					mismatches++;
				end
				if (result.phys_out !== want.phys_out) begin
					$error("phys_out: expected %h, got %h", want.phys_out, result.phys_out);
					mismatches++;
				end
			end
		end
	end

	// Watchdog for a hung block.
	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		req_word_t   w;
		rsp_word_t   predicted;
		rsp_word_t   none;
		logic [31:0] page;
		logic [9:0]  tbl;
		int          issued;
		int          burst;
		int          roll;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		none = '0;
		mismatches = 0;
		slots_used = 0;
		foreach (dir_valid[i]) begin
			dir_valid[i] = 1'b0;
			dir_slot_of[i] = 0;
		end
		foreach (pte_mem[i])
			pte_mem[i] = '0;

		// Directed part: errors first, then both ends of the address space.
		add_row(FN_XLATE, 32'h0040_0000, 32'h0, 12'h000, 1, ST_NOT_MAPPED);
		add_row(FN_MAP, 32'h0000_0000, 32'h0000_1000, 12'h001, 1, ST_BAD_ADDR);
		add_row(FN_MAP, 32'h0000_1000, 32'h0000_0000, 12'h001, 1, ST_BAD_ADDR);
		add_row(FN_MAP, 32'h0000_1001, 32'h0000_2000, 12'h001, 1, ST_BAD_ADDR);
		add_row(FN_MAP, 32'h0000_2000, 32'h0000_3FFF, 12'h001, 1, ST_BAD_ADDR);
		add_row(FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1, ST_BAD_ADDR);
		add_row(FN_UNMAP, 32'h0000_0000, 32'h0, 12'h000, 1, ST_BAD_ADDR);
		add_row(FN_XLATE, 32'h0000_0000, 32'h0, 12'h000, 1, ST_BAD_ADDR);
		add_row(FN_MAP, 32'hFFFF_F000, 32'hFFFF_F000, 12'hFFE, 0, ST_OK);
		add_row(FN_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h000, 0, ST_OK);
		add_row(FN_MAP, 32'hFFFF_F000, 32'h0000_1000, 12'h000, 1, ST_MAPPED);
		add_row(FN_XLATE, 32'hFFFF_F123, 32'h0, 12'h000, 0, ST_OK);
		add_row(FN_MAP, 32'h0000_1000, 32'h0000_1000, 12'h000, 0, ST_OK);
		add_row(FN_XLATE, 32'h0000_1ABC, 32'h0, 12'h000, 0, ST_OK);
		add_row(FN_UNMAP, 32'h0000_1FFF, 32'h0, 12'h000, 0, ST_OK);
		add_row(FN_UNMAP, 32'h0000_1000, 32'h0, 12'h000, 1, ST_NOT_MAPPED);
		add_row(FN_XLATE, 32'h0000_1000, 32'h0, 12'h000, 1, ST_NOT_MAPPED);
		add_row(FN_MAP, 32'h0000_1000, 32'h8000_0000, 12'h555, 0, ST_OK);
		add_row(FN_XLATE, 32'h0000_1FFF, 32'h0, 12'h000, 0, ST_OK);
		add_row(FN_XLATE, 32'h0040_2000, 32'h0, 12'h000, 1, ST_NOT_MAPPED);
		add_row(FN_UNMAP, 32'hFFC0_0000, 32'h0, 12'h000, 1, ST_NOT_MAPPED);
		add_row(FN_MAP, 32'h7FC0_0000, 32'h7FFF_F000, 12'hAAA, 0, ST_OK);

		// A small set of directory indexes makes the slots run out and pages collide.
		dir_pick[0] = 0;
		dir_pick[1] = DIR_ENTRIES - 1;
		for (int i = 2; i < DIR_PICKS; i++)
			dir_pick[i] = $urandom_range(0, DIR_ENTRIES - 1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			issue(plan[i].req, plan[i].typed, plan[i].want, predicted);
			idle_cycles($urandom_range(0, 3));
		end
		drain();

		// Random part: bursts of words with gaps, mostly on pages already seen.
		issued = 0;
		while (issued < RANDOM_WORDS) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && issued < RANDOM_WORDS; k++) begin
				roll = $urandom_range(0, 99);
				w.func = (roll < 40) ? FN_MAP : (roll < 60) ? FN_UNMAP :
					(roll < 95) ? FN_XLATE : FN_NONE;

				if (mapped_pages.size() > 0 && $urandom_range(0, 99) < 55) begin
					page = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
				end else begin
					tbl = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 7)) :
						10'($urandom);
					if ($urandom_range(0, 9) == 0)
						page = {10'($urandom), tbl, 12'h000};
					else
						page = {10'(dir_pick[$urandom_range(0, DIR_PICKS - 1)]), tbl, 12'h000};
				end

				w.vaddr = page;
				w.paddr = $urandom & 32'hFFFF_F000;
				w.page_flags = 12'($urandom);
				if (w.func == FN_MAP) begin
					// Occasional malformed map: misaligned or zero addresses.
					roll = $urandom_range(0, 99);
					if (roll < 3)
						w.vaddr[11:0] = 12'($urandom_range(1, 4095));
					else if (roll < 6)
						w.paddr = $urandom;
					else if (roll < 8)
						w.paddr = '0;
					else if (roll < 9)
						w.vaddr = '0;
				end else begin
					w.vaddr[11:0] = 12'($urandom);
					if ($urandom_range(0, 49) == 0)
						w.vaddr = '0;
				end

				issue(w, 1'b0, none, predicted);
				issued++;

				if (w.func == FN_MAP && predicted.status == ST_OK) begin
					mapped_pages.push_back(w.vaddr);
					if (mapped_pages.size() > PAGE_POOL_MAX)
						void'(mapped_pages.pop_front());
				end

				if (issued == RANDOM_WORDS / 2)
					drain();
			end
			// Roughly a third of bursts run straight into the next one.
			if ($urandom_range(0, 2) == 0)
				idle_cycles(0);
			else
				idle_cycles($urandom_range(1, 12));
		end

		drain();
		repeat (40) @(posedge clk);

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
